>>> src/jdqt_pkg.sv
// Package for the JPEG quantization-table extractor.
// Holds the parse phase and table target codes, marker constants and the word types.
// No dependencies.
`default_nettype none

package jdqt_pkg;

	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] MARKER_SOI    = 8'hD8;
	localparam logic [7:0] MARKER_SOS    = 8'hDA;
	localparam logic [7:0] MARKER_RST0   = 8'hD0;
	localparam logic [7:0] MARKER_RST7   = 8'hD7;
	localparam logic [7:0] MARKER_DQT    = 8'hDB;
	localparam logic [7:0] ROUND_HALF    = 8'h80;
	localparam logic [3:0] NIBBLE_MASK   = 4'hF;
	localparam logic [7:0] ENTRIES_NARROW = 8'd64;
	localparam logic [7:0] ENTRIES_WIDE   = 8'd128;
	localparam int         MIN_FRAME      = 4;

	typedef enum logic [3:0] {
		PH_SOI0 = 4'd0,
		PH_SOI1 = 4'd1,
		PH_SCAN = 4'd2,
		PH_FILL = 4'd3,
		PH_LENH = 4'd4,
		PH_LENL = 4'd5,
		PH_SKIP = 4'd6,
		PH_QHDR = 4'd7,
		PH_Q8   = 4'd8,
		PH_Q16  = 4'd9,
		PH_DONE = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		TGT_LUMA   = 2'd0,
		TGT_CHROMA = 2'd1,
		TGT_NONE   = 2'd2
	} target_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [23:0] frame_length;
		logic        frame_end;
	} byte_word_t;

	typedef struct packed {
		logic       is_summary;
		logic       table_select;
		logic [5:0] entry_index;
		logic [7:0] entry_value;
		logic       luma_present;
		logic       chroma_present;
		logic       wide_source;
		logic       any_table;
		logic       run_last;
	} result_word_t;

endpackage

`default_nettype wire

>>> src/jpeg_dqt_table_extractor_top.sv
// Top level of the JPEG quantization-table extractor: marker parser and result queue.
// Uses jdqt_pkg for types, phase codes and marker constants.
//
//  channel | signals                              | word
//  --------+--------------------------------------+----------------------
//  bytes   | byte_valid, byte_stall, byte_word    | jdqt_pkg::byte_word_t
//  results | result_valid, result_stall, result_word | jdqt_pkg::result_word_t
//
// One frame byte is parsed per cycle while byte_stall is low; its results enter a
// four-word queue in the same edge. A byte makes zero, one or two results; the queue
// drains one word per cycle while result_stall is low; two are an entry plus a summary.
// byte_stall is high while the queue has fewer than two free words.
// Reset clears parse state, flags and the queue; frame_end also returns the parser to reset.
`default_nettype none

module jpeg_dqt_table_extractor_top #(
	parameter int POSITION_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire jdqt_pkg::byte_word_t   byte_word,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output jdqt_pkg::result_word_t      result_word
);

	localparam int CW = ((POSITION_BITS > 24) ? POSITION_BITS : 24) + 2;

	// parser state
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	jdqt_pkg::phase_t         phase_q, phase_d;
	logic [7:0]               marker_q, marker_d;
	logic [7:0]               len_hi_q, len_hi_d;
	logic [15:0]              seg_left_q, seg_left_d;
	jdqt_pkg::target_t        target_q, target_d;
	logic [7:0]               entry_cnt_q, entry_cnt_d;
	logic [7:0]               wide_hi_q, wide_hi_d;
	logic                     luma_seen_q, luma_seen_d;
	logic                     chroma_seen_q, chroma_seen_d;
	logic                     wide_seen_q, wide_seen_d;

	// result queue
	jdqt_pkg::result_word_t   queue_q [4];
	logic [1:0]               wr_ptr_q, rd_ptr_q;
	logic [2:0]               count_q;

	logic                     byte_take, result_take;
	logic                     entry_hit;
	jdqt_pkg::result_word_t   entry_word, summary_word, first_word;
	logic [1:0]               push_cnt;

	logic [CW-1:0]  pos_x, len_x;
	logic [7:0]     b;
	logic [15:0]    seg_len;
	logic [15:0]    seg_dec;
	logic [3:0]     prec;
	logic [3:0]     tbl_id;
	logic [7:0]     need;
	logic [15:0]    wide_v;
	logic [16:0]    wide_sum;
	logic [7:0]     wide_v8;
	logic [7:0]     entry_val;
	logic [5:0]     entry_idx;
	logic [7:0]     cnt_inc;

	assign byte_stall  = (count_q > 3'd2);
	assign byte_take   = byte_valid && !byte_stall;
	assign result_valid = (count_q != 3'd0);
	assign result_take  = result_valid && !result_stall;
	assign result_word  = queue_q[rd_ptr_q];

	assign b        = byte_word.data_byte;
	assign pos_x    = CW'(pos_q);
	assign len_x    = CW'(byte_word.frame_length);
	assign seg_len  = {len_hi_q, b};
	assign seg_dec  = (seg_left_q != 16'd0) ? seg_left_q - 16'd1 : 16'd0;
	assign prec     = b[7:4];
	assign tbl_id   = b[3:0] & jdqt_pkg::NIBBLE_MASK;
	assign need     = (prec == 4'd0) ? jdqt_pkg::ENTRIES_NARROW : jdqt_pkg::ENTRIES_WIDE;
	assign wide_v   = {wide_hi_q, b};
	assign wide_sum = {1'b0, wide_v} + 17'({1'b0, jdqt_pkg::ROUND_HALF});
	assign wide_v8  = wide_sum[15:8];
	assign cnt_inc  = entry_cnt_q + 8'd1;

	always_comb begin
		pos_d         = pos_q;
		phase_d       = phase_q;
		marker_d      = marker_q;
		len_hi_d      = len_hi_q;
		seg_left_d    = seg_left_q;
		target_d      = target_q;
		entry_cnt_d   = entry_cnt_q;
		wide_hi_d     = wide_hi_q;
		luma_seen_d   = luma_seen_q;
		chroma_seen_d = chroma_seen_q;
		wide_seen_d   = wide_seen_q;
		entry_hit     = 1'b0;
		entry_val     = 8'd0;
		entry_idx     = 6'd0;

		if (pos_x < len_x) begin
			case (phase_q)
				jdqt_pkg::PH_SOI0: begin
					phase_d = (len_x < CW'(jdqt_pkg::MIN_FRAME) || b != jdqt_pkg::MARKER_PREFIX)
						? jdqt_pkg::PH_DONE : jdqt_pkg::PH_SOI1;
				end
				jdqt_pkg::PH_SOI1: begin
					phase_d = (b == jdqt_pkg::MARKER_SOI) ? jdqt_pkg::PH_SCAN : jdqt_pkg::PH_DONE;
				end
				jdqt_pkg::PH_SCAN: begin
					if (!(pos_x + CW'(3) < len_x))
						phase_d = jdqt_pkg::PH_DONE;
					else if (b == jdqt_pkg::MARKER_PREFIX)
						phase_d = jdqt_pkg::PH_FILL;
				end
				jdqt_pkg::PH_FILL: begin
					if (b == jdqt_pkg::MARKER_PREFIX) begin
						phase_d = jdqt_pkg::PH_FILL;
					end else if (b == jdqt_pkg::MARKER_SOS) begin
						phase_d = jdqt_pkg::PH_DONE;
					end else if (b inside {[jdqt_pkg::MARKER_RST0:jdqt_pkg::MARKER_RST7]}) begin
						phase_d = jdqt_pkg::PH_SCAN;
					end else begin
						marker_d = b;
						phase_d  = (pos_x + CW'(2) < len_x) ? jdqt_pkg::PH_LENH : jdqt_pkg::PH_DONE;
					end
				end
				jdqt_pkg::PH_LENH: begin
					len_hi_d = b;
					phase_d  = jdqt_pkg::PH_LENL;
				end
				jdqt_pkg::PH_LENL: begin
					if (seg_len < 16'd2 ||
					    pos_x + CW'(1) + CW'(seg_len - 16'd2) > len_x) begin
						phase_d = jdqt_pkg::PH_DONE;
					end else begin
						seg_left_d = seg_len - 16'd2;
						if (seg_len == 16'd2)
							phase_d = jdqt_pkg::PH_SCAN;
						else
							phase_d = (marker_q == jdqt_pkg::MARKER_DQT)
								? jdqt_pkg::PH_QHDR : jdqt_pkg::PH_SKIP;
					end
				end
				jdqt_pkg::PH_SKIP: begin
					seg_left_d = seg_dec;
					if (seg_dec == 16'd0)
						phase_d = jdqt_pkg::PH_SCAN;
				end
				jdqt_pkg::PH_QHDR: begin
					seg_left_d = seg_dec;
					if (16'(need) > seg_dec) begin
						// truncated table: drop the rest of the segment
						phase_d = (seg_dec != 16'd0) ? jdqt_pkg::PH_SKIP : jdqt_pkg::PH_SCAN;
					end else begin
						if (tbl_id == 4'd0) begin
							target_d    = jdqt_pkg::TGT_LUMA;
							luma_seen_d = 1'b1;
						end else if (tbl_id == 4'd1) begin
							target_d      = jdqt_pkg::TGT_CHROMA;
							chroma_seen_d = 1'b1;
						end else begin
							target_d = jdqt_pkg::TGT_NONE;
						end
						if (prec != 4'd0)
							wide_seen_d = 1'b1;
						entry_cnt_d = 8'd0;
						phase_d = (prec == 4'd0) ? jdqt_pkg::PH_Q8 : jdqt_pkg::PH_Q16;
					end
				end
				jdqt_pkg::PH_Q8: begin
					entry_hit   = (target_q != jdqt_pkg::TGT_NONE);
					entry_idx   = entry_cnt_q[5:0];
					entry_val   = (b == 8'd0) ? 8'd1 : b;
					entry_cnt_d = cnt_inc;
					seg_left_d  = seg_dec;
					if (cnt_inc >= jdqt_pkg::ENTRIES_NARROW)
						phase_d = (seg_dec != 16'd0) ? jdqt_pkg::PH_QHDR : jdqt_pkg::PH_SCAN;
				end
				jdqt_pkg::PH_Q16: begin
					if (!entry_cnt_q[0]) begin
						wide_hi_d = b;
					end else begin
						entry_hit = (target_q != jdqt_pkg::TGT_NONE);
						entry_idx = entry_cnt_q[6:1];
						entry_val = (wide_v == 16'd0 || wide_v8 == 8'd0) ? 8'd1 : wide_v8;
					end
					entry_cnt_d = cnt_inc;
					seg_left_d  = seg_dec;
					if (cnt_inc >= jdqt_pkg::ENTRIES_WIDE)
						phase_d = (seg_dec != 16'd0) ? jdqt_pkg::PH_QHDR : jdqt_pkg::PH_SCAN;
				end
				default: begin
					phase_d = jdqt_pkg::PH_DONE;
				end
			endcase
		end

		if (pos_q != {POSITION_BITS{1'b1}})
			pos_d = pos_q + POSITION_BITS'(1);

		// entry and summary words
		entry_word                = '0;
		entry_word.table_select   = target_q[0];
		entry_word.entry_index    = entry_idx;
		entry_word.entry_value    = entry_val;
		entry_word.run_last       = !byte_word.frame_end;

		summary_word                = '0;
		summary_word.is_summary     = 1'b1;
		summary_word.luma_present   = luma_seen_d;
		summary_word.chroma_present = chroma_seen_d;
		summary_word.wide_source    = wide_seen_d;
		summary_word.any_table      = luma_seen_d | chroma_seen_d;
		summary_word.run_last       = 1'b1;

		first_word = entry_hit ? entry_word : summary_word;
		push_cnt   = 2'(entry_hit) + 2'(byte_word.frame_end);

		if (byte_word.frame_end) begin
			pos_d         = '0;
			phase_d       = jdqt_pkg::PH_SOI0;
			marker_d      = 8'd0;
			len_hi_d      = 8'd0;
			seg_left_d    = 16'd0;
			target_d      = jdqt_pkg::TGT_NONE;
			entry_cnt_d   = 8'd0;
			wide_hi_d     = 8'd0;
			luma_seen_d   = 1'b0;
			chroma_seen_d = 1'b0;
			wide_seen_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			phase_q       <= jdqt_pkg::PH_SOI0;
			marker_q      <= 8'd0;
			len_hi_q      <= 8'd0;
			seg_left_q    <= 16'd0;
			target_q      <= jdqt_pkg::TGT_NONE;
			entry_cnt_q   <= 8'd0;
			wide_hi_q     <= 8'd0;
			luma_seen_q   <= 1'b0;
			chroma_seen_q <= 1'b0;
			wide_seen_q   <= 1'b0;
		end else if (byte_take) begin
			pos_q         <= pos_d;
			phase_q       <= phase_d;
			marker_q      <= marker_d;
			len_hi_q      <= len_hi_d;
			seg_left_q    <= seg_left_d;
			target_q      <= target_d;
			entry_cnt_q   <= entry_cnt_d;
			wide_hi_q     <= wide_hi_d;
			luma_seen_q   <= luma_seen_d;
			chroma_seen_q <= chroma_seen_d;
			wide_seen_q   <= wide_seen_d;
		end
	end

	// queue storage: up to two words written per byte
	always_ff @(posedge clk) begin
		if (byte_take && push_cnt != 2'd0)
			queue_q[wr_ptr_q] <= first_word;
		if (byte_take && push_cnt == 2'd2)
			queue_q[wr_ptr_q + 2'd1] <= summary_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (byte_take)
				wr_ptr_q <= wr_ptr_q + push_cnt;
			if (result_take)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + (byte_take ? 3'(push_cnt) : 3'd0) - 3'(result_take);
		end
	end

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 3'd4)
		else $error("result queue overflow");

	// occupancy tracks pushes and pops
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + ($past(byte_take) ? 3'($past(push_cnt)) : 3'd0)
			- 3'($past(result_take)))
		else $error("queue count mismatch");

	// frame end puts the parser back to its start
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_take && byte_word.frame_end |=>
			phase_q == jdqt_pkg::PH_SOI0 && pos_q == '0 && !luma_seen_q && !wide_seen_q)
		else $error("parser not reset after frame end");

	// a byte with frame end always queues a summary after its entry
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_take && byte_word.frame_end |-> push_cnt == 2'(entry_hit) + 2'd1)
		else $error("summary missing");

	// in the narrow table phase the entry counter stays below 64
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == jdqt_pkg::PH_Q8 |-> entry_cnt_q < jdqt_pkg::ENTRIES_NARROW)
		else $error("narrow table counter overrun");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for jpeg_dqt_table_extractor_top: streams JPEG frame bytes and checks
// every result word against a scoreboard that predicts the DQT parse in step with the block.
// Depends on jdqt_pkg and jpeg_dqt_table_extractor_top.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_BITS    = 24;
	localparam int ITEM_TARGET = 1550;
	localparam int SHOWN_LIMIT = 10;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   byte_valid = 1'b0;
	logic                   byte_stall;
	jdqt_pkg::byte_word_t   byte_word = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	jdqt_pkg::result_word_t result_word;

	jpeg_dqt_table_extractor_top #(
		.POSITION_BITS(POS_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word (result_word)
	);

	always #6 clk = ~clk;

	// Tracks the parser of one frame and holds the result words it must produce.
	class quant_scoreboard;
		jdqt_pkg::phase_t       phase;
		jdqt_pkg::target_t      target;
		logic [POS_BITS-1:0]    position;
		logic [7:0]             marker;
		logic [7:0]             len_hi;
		logic [7:0]             wide_hi;
		int unsigned            seg_left;
		int unsigned            entry_cnt;
		bit                     luma_seen;
		bit                     chroma_seen;
		bit                     wide_seen;
		jdqt_pkg::result_word_t expected_q[$];
		int                     mismatches;
		int                     entries_checked;
		int                     summaries_checked;

		function new();
			mismatches = 0;
			entries_checked = 0;
			summaries_checked = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			position = '0;
			phase = jdqt_pkg::PH_SOI0;
			marker = '0;
			len_hi = '0;
			seg_left = 0;
			target = jdqt_pkg::TGT_NONE;
			entry_cnt = 0;
			wide_hi = '0;
			luma_seen = 1'b0;
			chroma_seen = 1'b0;
			wide_seen = 1'b0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_byte(jdqt_pkg::byte_word_t w);
			int unsigned            pos;
			int unsigned            flen;
			int unsigned            seg;
			int unsigned            need;
			int unsigned            idx;
			logic [7:0]             b;
			logic [3:0]             prec;
			logic [3:0]             id;
			logic [15:0]            wide_val;
			logic [16:0]            rounded;
			logic [7:0]             val8;
			bit                     have_entry;
			jdqt_pkg::result_word_t entry;
			jdqt_pkg::result_word_t summary;
			b = w.data_byte;
			pos = 32'(position);
			flen = 32'(w.frame_length);
			have_entry = 1'b0;
			idx = 0;
			val8 = '0;
			if (pos < flen) begin
				case (phase)
					jdqt_pkg::PH_SOI0: begin
						if (flen < jdqt_pkg::MIN_FRAME || b != jdqt_pkg::MARKER_PREFIX)
							phase = jdqt_pkg::PH_DONE;
						else phase = jdqt_pkg::PH_SOI1;
					end
					jdqt_pkg::PH_SOI1: begin
						if (b == jdqt_pkg::MARKER_SOI) phase = jdqt_pkg::PH_SCAN;
						else phase = jdqt_pkg::PH_DONE;
					end
					jdqt_pkg::PH_SCAN: begin
						if (!(pos + 3 < flen)) phase = jdqt_pkg::PH_DONE;
						else if (b == jdqt_pkg::MARKER_PREFIX) phase = jdqt_pkg::PH_FILL;
					end
					jdqt_pkg::PH_FILL: begin
						if (b == jdqt_pkg::MARKER_PREFIX) begin
							// fill byte, keep looking for the marker code
						end else if (b == jdqt_pkg::MARKER_SOS) begin
							phase = jdqt_pkg::PH_DONE;
						end else if (b >= jdqt_pkg::MARKER_RST0 &&
							b <= jdqt_pkg::MARKER_RST7) begin
							phase = jdqt_pkg::PH_SCAN;
						end else begin
							marker = b;
							if (pos + 2 < flen) phase = jdqt_pkg::PH_LENH;
							else phase = jdqt_pkg::PH_DONE;
						end
					end
					jdqt_pkg::PH_LENH: begin
						len_hi = b;
						phase = jdqt_pkg::PH_LENL;
					end
					jdqt_pkg::PH_LENL: begin
						seg = 32'({len_hi, b});
						if (seg < 2 || pos + 1 + (seg - 2) > flen) begin
							phase = jdqt_pkg::PH_DONE;
						end else begin
							seg_left = seg - 2;
							if (seg_left == 0) phase = jdqt_pkg::PH_SCAN;
							else if (marker == jdqt_pkg::MARKER_DQT) phase = jdqt_pkg::PH_QHDR;
							else phase = jdqt_pkg::PH_SKIP;
						end
					end
					jdqt_pkg::PH_SKIP: begin
						if (seg_left > 0) seg_left--;
						if (seg_left == 0) phase = jdqt_pkg::PH_SCAN;
					end
					jdqt_pkg::PH_QHDR: begin
						prec = b[7:4];
						id = b[3:0];
						need = (prec == 4'd0) ? 32'(jdqt_pkg::ENTRIES_NARROW) :
							32'(jdqt_pkg::ENTRIES_WIDE);
						if (seg_left > 0) seg_left--;
						if (need > seg_left) begin
							// table cut short by its segment: drop the rest silently
							if (seg_left > 0) phase = jdqt_pkg::PH_SKIP;
							else phase = jdqt_pkg::PH_SCAN;
						end else begin
							if (id == 4'd0) begin
								target = jdqt_pkg::TGT_LUMA;
								luma_seen = 1'b1;
							end else if (id == 4'd1) begin
								target = jdqt_pkg::TGT_CHROMA;
								chroma_seen = 1'b1;
							end else begin
								target = jdqt_pkg::TGT_NONE;
							end
							if (prec != 4'd0) wide_seen = 1'b1;
							entry_cnt = 0;
							if (prec == 4'd0) phase = jdqt_pkg::PH_Q8;
							else phase = jdqt_pkg::PH_Q16;
						end
					end
					jdqt_pkg::PH_Q8: begin
						if (target != jdqt_pkg::TGT_NONE) begin
							val8 = (b == 8'd0) ? 8'd1 : b;
							idx = entry_cnt;
							have_entry = 1'b1;
						end
						entry_cnt++;
						if (seg_left > 0) seg_left--;
						if (entry_cnt >= jdqt_pkg::ENTRIES_NARROW) begin
							if (seg_left > 0) phase = jdqt_pkg::PH_QHDR;
							else phase = jdqt_pkg::PH_SCAN;
						end
					end
					jdqt_pkg::PH_Q16: begin
						if (entry_cnt[0] == 1'b0) begin
							wide_hi = b;
						end else if (target != jdqt_pkg::TGT_NONE) begin
							wide_val = {wide_hi, b};
							rounded = {1'b0, wide_val} + {9'd0, jdqt_pkg::ROUND_HALF};
							val8 = rounded[15:8];
							if (wide_val == 16'd0 || val8 == 8'd0) val8 = 8'd1;
							idx = entry_cnt >> 1;
							have_entry = 1'b1;
						end
						entry_cnt++;
						if (seg_left > 0) seg_left--;
						if (entry_cnt >= jdqt_pkg::ENTRIES_WIDE) begin
							if (seg_left > 0) phase = jdqt_pkg::PH_QHDR;
							else phase = jdqt_pkg::PH_SCAN;
						end
					end
					default: phase = jdqt_pkg::PH_DONE;
				endcase
			end
			if (position != {POS_BITS{1'b1}}) position++;
			if (have_entry) begin
				entry = '0;
				entry.table_select = (target == jdqt_pkg::TGT_CHROMA);
				entry.entry_index = idx[5:0];
				entry.entry_value = val8;
				entry.run_last = !w.frame_end;
				expected_q.push_back(entry);
			end
			if (w.frame_end) begin
				summary = '0;
				summary.is_summary = 1'b1;
				summary.luma_present = luma_seen;
				summary.chroma_present = chroma_seen;
				summary.wide_source = wide_seen;
				summary.any_table = luma_seen | chroma_seen;
				summary.run_last = 1'b1;
				expected_q.push_back(summary);
				clear_frame();
			end
		endfunction

		function string show(jdqt_pkg::result_word_t r);
			return $sformatf("sum=%0b tbl=%0b idx=%0d val=%0d luma/chroma/wide/any=%b%b%b%b last=%0b",
				r.is_summary, r.table_select, r.entry_index, r.entry_value, r.luma_present,
				r.chroma_present, r.wide_source, r.any_table, r.run_last);
		endfunction

		function void check_result(jdqt_pkg::result_word_t got);
			jdqt_pkg::result_word_t exp;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_LIMIT)
					$display("%0t: result word with nothing expected: %s", $time, show(got));
				return;
			end
			exp = expected_q.pop_front();
			if (exp.is_summary) summaries_checked++;
			else entries_checked++;
			if (got.is_summary !== exp.is_summary || got.table_select !== exp.table_select ||
				got.entry_index !== exp.entry_index || got.entry_value !== exp.entry_value ||
				got.luma_present !== exp.luma_present ||
				got.chroma_present !== exp.chroma_present ||
				got.wide_source !== exp.wide_source || got.any_table !== exp.any_table ||
				got.run_last !== exp.run_last) begin
				mismatches++;
				if (mismatches <= SHOWN_LIMIT)
					$display("%0t: result word mismatch\n  expected %s\n  actual   %s",
						$time, show(exp), show(got));
			end
		endfunction
	endclass

	quant_scoreboard sb;
	logic [7:0]      frame_bytes[$];
	int              burst_left = 0;
	int              items_sent = 0;
	int              frames_sent = 0;
	int unsigned     stall_mode = 0;
	int unsigned     stall_span = 0;
	int unsigned     stall_tick = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) sb.note_byte(byte_word);
			if (result_valid && !result_stall) sb.check_result(result_word);
		end
	end

	// Result side: switches between no stall, random, periodic and heavy stall patterns.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(20, 300);
		end
		stall_span--;
		stall_tick++;
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 99) < 30);
			2: result_stall <= ((stall_tick % 7) < 3);
			default: result_stall <= ($urandom_range(0, 99) < 75);
		endcase
	end

	task automatic send_byte(input jdqt_pkg::byte_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_word <= w;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_frame(input int unsigned flen, input bit with_end);
		jdqt_pkg::byte_word_t w;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			w.data_byte = frame_bytes[i];
			w.frame_length = flen[23:0];
			w.frame_end = with_end && (i == frame_bytes.size() - 1);
			send_byte(w);
		end
		frames_sent++;
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Random frame: SOI, one to four segments (about half DQT), usually SOS; now and then pure noise.
	task automatic build_frame();
		int         segs;
		int         kind;
		int         pick;
		int         prec;
		int         id;
		int         need;
		int         k;
		int         ntab;
		int         m;
		int         body;
		int         seglen;
		logic [15:0] v;
		logic [7:0]  tq[$];
		frame_bytes.delete();
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 1) == 1) begin
				frame_bytes.push_back(jdqt_pkg::MARKER_PREFIX);
				frame_bytes.push_back(jdqt_pkg::MARKER_SOI);
			end
			repeat ($urandom_range(1, 40))
				frame_bytes.push_back(($urandom_range(0, 3) == 0) ? jdqt_pkg::MARKER_PREFIX :
					8'($urandom_range(0, 255)));
			return;
		end
		frame_bytes.push_back(jdqt_pkg::MARKER_PREFIX);
		frame_bytes.push_back(jdqt_pkg::MARKER_SOI);
		segs = $urandom_range(1, 4);
		repeat (segs) begin
			kind = $urandom_range(0, 11);
			case (kind)
				0: begin
					repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 254)));
				end
				1, 2: begin
					repeat ($urandom_range(1, 3)) frame_bytes.push_back(jdqt_pkg::MARKER_PREFIX);
					frame_bytes.push_back(8'($urandom_range(jdqt_pkg::MARKER_RST0,
						jdqt_pkg::MARKER_RST7)));
				end
				3, 4, 5: begin
					do m = $urandom_range(0, 254);
					while ((m >= jdqt_pkg::MARKER_RST0 && m <= jdqt_pkg::MARKER_RST7) ||
						m == jdqt_pkg::MARKER_SOS || m == jdqt_pkg::MARKER_DQT);
					frame_bytes.push_back(jdqt_pkg::MARKER_PREFIX);
					frame_bytes.push_back(8'(m));
					if (kind == 5 && $urandom_range(0, 1) == 0) begin
						// length field below two
						frame_bytes.push_back(8'd0);
						frame_bytes.push_back(8'($urandom_range(0, 1)));
					end else begin
						body = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300) :
							$urandom_range(0, 12);
						seglen = body + 2;
						frame_bytes.push_back(8'(seglen >> 8));
						frame_bytes.push_back(8'(seglen));
						repeat (body) frame_bytes.push_back(8'($urandom_range(0, 255)));
					end
				end
				default: begin
					tq.delete();
					ntab = ($urandom_range(0, 3) == 0) ? 2 : 1;
					for (int t = 0; t < ntab; t++) begin
						pick = $urandom_range(0, 19);
						prec = (pick < 10) ? 0 : (pick < 17) ? 1 : $urandom_range(2, 15);
						pick = $urandom_range(0, 9);
						id = (pick < 4) ? 0 : (pick < 8) ? 1 : $urandom_range(2, 15);
						tq.push_back({prec[3:0], id[3:0]});
						need = (prec == 0) ? int'(jdqt_pkg::ENTRIES_NARROW) :
							int'(jdqt_pkg::ENTRIES_WIDE);
						if (t == ntab - 1 && $urandom_range(0, 7) == 0)
							need = $urandom_range(0, need - 1);
						k = 0;
						while (k < need) begin
							if (prec == 0) begin
								pick = $urandom_range(0, 9);
								tq.push_back((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
									8'($urandom_range(1, 254)));
								k++;
							end else begin
								pick = $urandom_range(0, 11);
								case (pick)
									0: v = 16'h0000;
									1: v = 16'h007F;
									2: v = 16'h0080;
									3: v = 16'hFFFF;
									4: v = 16'hFF7F;
									5, 6: v = 16'($urandom_range(0, 1023));
									default: v = 16'($urandom_range(0, 65535));
								endcase
								tq.push_back(v[15:8]);
								tq.push_back(v[7:0]);
								k += 2;
							end
						end
					end
					// a few spare bytes leave a header that cannot hold a table
					if ($urandom_range(0, 9) == 0)
						repeat ($urandom_range(1, 3)) tq.push_back(8'($urandom_range(0, 255)));
					seglen = tq.size() + 2;
					frame_bytes.push_back(jdqt_pkg::MARKER_PREFIX);
					frame_bytes.push_back(jdqt_pkg::MARKER_DQT);
					frame_bytes.push_back(8'(seglen >> 8));
					frame_bytes.push_back(8'(seglen));
					foreach (tq[i]) frame_bytes.push_back(tq[i]);
				end
			endcase
		end
		if ($urandom_range(0, 4) != 0) begin
			frame_bytes.push_back(jdqt_pkg::MARKER_PREFIX);
			frame_bytes.push_back(jdqt_pkg::MARKER_SOS);
			repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int unsigned flen;
		int          pick;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length: the byte lies past the frame
		frame_bytes = '{jdqt_pkg::MARKER_PREFIX};
		send_frame(0, 1'b1);
		// shorter than four bytes
		frame_bytes = '{jdqt_pkg::MARKER_PREFIX, jdqt_pkg::MARKER_SOI, jdqt_pkg::MARKER_PREFIX};
		send_frame(3, 1'b1);
		// start marker missing
		frame_bytes = '{8'h00, jdqt_pkg::MARKER_SOI, 8'h00, 8'h00};
		send_frame(4, 1'b1);
		// bad second byte, end comes early
		frame_bytes = '{jdqt_pkg::MARKER_PREFIX, 8'h00};
		send_frame(4, 1'b1);
		// restart marker, fill byte, then start-of-scan
		frame_bytes = '{jdqt_pkg::MARKER_PREFIX, jdqt_pkg::MARKER_SOI, jdqt_pkg::MARKER_PREFIX,
			jdqt_pkg::MARKER_RST0 + 8'd3, jdqt_pkg::MARKER_PREFIX, jdqt_pkg::MARKER_PREFIX,
			jdqt_pkg::MARKER_SOS, 8'h00, 8'h00};
		send_frame(9, 1'b1);
		// largest length and byte values
		frame_bytes = '{jdqt_pkg::MARKER_PREFIX};
		send_frame(24'hFFFFFF, 1'b1);
		// segment length below two
		frame_bytes = '{jdqt_pkg::MARKER_PREFIX, jdqt_pkg::MARKER_SOI, jdqt_pkg::MARKER_PREFIX,
			8'hE1, 8'h00, 8'h01};
		send_frame(6, 1'b1);
		wait_drained();

		while (items_sent < ITEM_TARGET) begin
			build_frame();
			flen = frame_bytes.size();
			pick = $urandom_range(0, 99);
			if (pick < 8) flen = flen - $urandom_range(1, (flen < 10) ? flen : 10);
			else if (pick < 15) flen = flen + $urandom_range(1, 300);
			else if (pick < 18) flen = $urandom_range(0, 24'hFFFFFF);
			else if (pick < 21) flen = $urandom_range(0, 3);
			send_frame(flen, $urandom_range(0, 19) != 0);
			if (frames_sent % 5 == 4) wait_drained();
		end
		wait_drained();
		repeat (16) @(posedge clk);

		$display("Sent %0d frames, %0d bytes: short, noisy and well-formed frames with DQT tables",
			frames_sent, items_sent);
		$display("of both precisions; checked %0d table entries, %0d summaries, %0d mismatches.",
			sb.entries_checked, sb.summaries_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout with %0d result words still expected", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
src/jdqt_pkg.sv
src/jpeg_dqt_table_extractor_top.sv
verif/tb_top.sv
